>>> rtl/light_sensor_average_lamp_control_core_assert.svh
// ----------------------------------------------------------------------------
// Light sensor average lamp control - assertion macros
// Concurrent assertion forms used by the core's back end.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SENSOR_AVERAGE_LAMP_CONTROL_CORE_ASSERT_SVH
`define LIGHT_SENSOR_AVERAGE_LAMP_CONTROL_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSALC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsalc assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define LSALC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsalc assertion failed: next-cycle implication");

`endif

>>> rtl/lsalc_pkg.sv
// ----------------------------------------------------------------------------
// Light sensor average lamp control - package
// Shared widths, codes, types and the lamp decision function.
// ----------------------------------------------------------------------------
package lsalc_pkg;

   localparam int SAMPLE_W        = 12;
   localparam int LAMP_W          = 2;
   localparam int WINDOW_SIZE_DEF = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 16;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_IDX_W       = 2;

   localparam logic [SAMPLE_W-1:0] THR_LOW_RESET  = SAMPLE_W'(1000);
   localparam logic [SAMPLE_W-1:0] THR_HIGH_RESET = SAMPLE_W'(3000);

   // Register indexes (byte address divided by four).
   localparam logic [CSR_IDX_W-1:0] REG_THR_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THR_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD     = 2'd2;

   typedef enum logic [LAMP_W-1:0] {
      LAMP_OFF  = 2'd0,
      LAMP_HALF = 2'd1,
      LAMP_FULL = 2'd2
   } lamp_type;

   // What the back end has to do with an item.
   typedef enum logic [1:0] {
      KIND_FAIL = 2'd0,   // failed read: average 0, window untouched
      KIND_KEEP = 2'd1,   // good read of zero: window untouched
      KIND_PUSH = 2'd2    // good nonzero sample: enters the window
   } kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_UPD,
      BK_START,
      BK_DIV,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [SAMPLE_W-1:0] sample;
   } queue_out_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] thr_low;
      logic [SAMPLE_W-1:0] thr_high;
      logic                hold;
   } cfg_type;

   // Lamp hysteresis rule. Unless held, a zero average first forces full.
   function automatic lamp_type lamp_next(input logic [SAMPLE_W-1:0] avg,
                                          input lamp_type cur,
                                          input cfg_type cfg);
      lamp_type s;
      lamp_type r;
      s = (avg == '0) ? LAMP_FULL : cur;
      r = s;
      if (cfg.hold) begin
         r = cur;
      end else if (s != LAMP_OFF) begin
         priority if (avg >= cfg.thr_high) r = LAMP_OFF;
         else if (avg <= cfg.thr_low) r = s;
         else r = LAMP_HALF;
      end else begin
         priority if (avg <= cfg.thr_low) r = LAMP_FULL;
         else if (avg >= cfg.thr_high) r = LAMP_OFF;
         else r = LAMP_HALF;
      end
      return r;
   endfunction

endpackage

>>> rtl/lsalc_ram.sv
// ----------------------------------------------------------------------------
// Light sensor average lamp control - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsalc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/lsalc_front.sv
// ----------------------------------------------------------------------------
// Light sensor average lamp control - front end
// Accepts items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lsalc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lsalc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            pop,
   output lsalc_pkg::queue_out_type        q_out
);
   import lsalc_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   kind_type            kind_ff     [QUEUE_DEPTH];
   logic [SAMPLE_W-1:0] sample_ff   [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                do_pop;
   kind_type            kind;
   logic [SAMPLE_W-1:0] sample;

   assign sample = req_tdata[SAMPLE_W-1:0];

   always_comb begin
      priority if (!req_tuser) kind = KIND_FAIL;
      else if (sample == '0) kind = KIND_KEEP;
      else kind = KIND_PUSH;
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff]   <= kind;
         sample_ff[wr_ptr_ff] <= sample;
      end
   end

   assign q_out.valid  = (count_ff != '0);
   assign q_out.kind   = kind_ff[rd_ptr_ff];
   assign q_out.sample = sample_ff[rd_ptr_ff];

endmodule

>>> rtl/lsalc_back.sv
// ----------------------------------------------------------------------------
// Light sensor average lamp control - back end
// Window update, serial division of sum by count, lamp decision, result
// register.
// ----------------------------------------------------------------------------
`include "light_sensor_average_lamp_control_core_assert.svh"

module lsalc_back #(
   parameter int WINDOW_SIZE = lsalc_pkg::WINDOW_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lsalc_pkg::queue_out_type         q_in,
   output logic                             pop,
   input  lsalc_pkg::cfg_type               cfg,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lsalc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import lsalc_pkg::*;

   localparam int PTR_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W + 1);

   back_state_type      state_ff, state_in;
   logic [PTR_W-1:0]    wptr_ff, wptr_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   lamp_type            lamp_ff, lamp_in;
   logic                out_valid_ff, out_valid_in;
   kind_type            kind_ff, kind_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [SAMPLE_W-1:0] out_avg_ff, out_avg_in;
   lamp_type            out_lamp_ff, out_lamp_in;

   logic                full;
   logic                last_step;
   logic                load;
   logic                ram_we;
   logic                ram_re;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic [CNT_W:0]      shifted;
   logic                ge;

   assign full      = (fill_ff == CNT_W'(WINDOW_SIZE));
   assign last_step = (step_ff == STEP_W'(SUM_W - 1));
   assign load      = (state_ff == BK_DONE) && (!out_valid_ff || rsp_tready);
   assign pop       = (state_ff == BK_IDLE) && q_in.valid;
   assign ram_re    = pop;
   assign ram_we    = (state_ff == BK_UPD);

   // When the window is full the oldest entry sits where the next write goes.
   lsalc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_SIZE)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (wptr_ff),
      .wdata (sample_ff),
      .re    (ram_re),
      .raddr (wptr_ff),
      .rdata (ram_rdata)
   );

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign ge      = (shifted >= {1'b0, fill_ff});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_in.valid) begin
               unique case (q_in.kind)
                  KIND_PUSH: state_in = BK_UPD;
                  KIND_KEEP: state_in = BK_START;
                  KIND_FAIL: state_in = BK_DONE;
                  default:   state_in = BK_DONE;
               endcase
            end
         end
         BK_UPD:   state_in = BK_START;
         BK_START: state_in = (fill_ff == '0) ? BK_DONE : BK_DIV;
         BK_DIV:   state_in = last_step ? BK_DONE : BK_DIV;
         BK_DONE:  state_in = load ? BK_IDLE : BK_DONE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      wptr_in     = wptr_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      lamp_in     = lamp_ff;
      kind_in     = kind_ff;
      sample_in   = sample_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      avg_in      = avg_ff;
      out_avg_in  = out_avg_ff;
      out_lamp_in = out_lamp_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_in.valid) begin
               kind_in   = q_in.kind;
               sample_in = q_in.sample;
               avg_in    = '0;
            end
         end
         BK_UPD: begin
            sum_in  = sum_ff - (full ? SUM_W'(ram_rdata) : '0) + SUM_W'(sample_ff);
            wptr_in = (wptr_ff == PTR_W'(WINDOW_SIZE - 1)) ? '0 : wptr_ff + 1'b1;
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         BK_START: begin
            rem_in  = '0;
            quo_in  = sum_ff;
            step_in = '0;
            avg_in  = '0;
         end
         BK_DIV: begin
            rem_in  = ge ? CNT_W'(shifted - {1'b0, fill_ff}) : shifted[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (last_step) begin
               avg_in = quo_in[SAMPLE_W-1:0];
            end
         end
         BK_DONE: begin
            if (load) begin
               lamp_in     = lamp_next(avg_ff, lamp_ff, cfg);
               out_avg_in  = avg_ff;
               out_lamp_in = lamp_in;
            end
         end
         default: begin
         end
      endcase
      out_valid_in = load || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         lamp_ff      <= LAMP_OFF;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         lamp_ff      <= lamp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      sample_ff   <= sample_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      avg_ff      <= avg_in;
      out_avg_ff  <= out_avg_in;
      out_lamp_ff <= out_lamp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SAMPLE_W - LAMP_W)'(0), out_lamp_ff, out_avg_ff};

   `LSALC_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(WINDOW_SIZE))
   `LSALC_ASSERT_SAME(a_wptr_bound, clock, reset, 1'b1, wptr_ff <= PTR_W'(WINDOW_SIZE - 1))
   `LSALC_ASSERT_SAME(a_fail_zero, clock, reset, state_ff == BK_DONE && kind_ff == KIND_FAIL, avg_ff == '0)
   `LSALC_ASSERT_NEXT(a_hold_lamp, clock, reset, load && cfg.hold, lamp_ff == $past(lamp_ff))

endmodule

>>> rtl/light_sensor_average_lamp_control_core.sv
// ----------------------------------------------------------------------------
// Light sensor average lamp control core
// Sliding-window light average with hysteresis lamp control, APB registers.
// ----------------------------------------------------------------------------
// Each item on the req_ channel carries one 12-bit light sample and a read-ok
// flag, and produces exactly one result item on the rsp_ channel with the
// window average and the new lamp level (0 off, 1 half, 2 full). A front end
// takes items into a two-entry queue, so the channel keeps accepting while the
// back end works and while a finished result waits in the output register,
// until both queue entries are full. The back end handles one item at a time:
// a failed read goes straight to the lamp decision, a good zero sample runs the
// divider unless the window is empty, and a pushed sample first updates the
// window and then runs the divider. The restoring divider produces one quotient
// bit per cycle of the running sum over the fill count and runs 12 plus the
// number of bits that hold WINDOW_SIZE steps (17 at the default window of 16).
// The window lives in a small RAM with a registered read port; its contents
// need no clearing, so the block is ready right after reset. Registers:
// threshold_low at byte address 0 (reset 1000), threshold_high at 4 (reset
// 3000) and manual_hold at 8 (reset 0); write them only while the block is
// idle.
// ----------------------------------------------------------------------------
module light_sensor_average_lamp_control_core #(
   parameter int WINDOW_SIZE = lsalc_pkg::WINDOW_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input items.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lsalc_pkg::REQ_DATA_W-1:0] req_tdata,   // [11:0] sample
   input  logic                             req_tuser,   // [0] read_ok
   // Result items.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lsalc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [11:0] average, [13:12] lamp_level
   // Register port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lsalc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lsalc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lsalc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import lsalc_pkg::*;

   logic [SAMPLE_W-1:0]  thr_low_ff, thr_high_ff;
   logic                 hold_ff;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;
   cfg_type              cfg;
   queue_out_type        q_out;
   logic                 pop;

   // The register port never waits; a write lands on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_low_ff  <= THR_LOW_RESET;
         thr_high_ff <= THR_HIGH_RESET;
         hold_ff     <= 1'b0;
      end else if (csr_write) begin
         // Writes to the unused index are dropped.
         unique case (csr_idx)
            REG_THR_LOW:  thr_low_ff  <= csr_pwdata[SAMPLE_W-1:0];
            REG_THR_HIGH: thr_high_ff <= csr_pwdata[SAMPLE_W-1:0];
            REG_HOLD:     hold_ff     <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_THR_LOW:  csr_prdata = CSR_DATA_W'(thr_low_ff);
         REG_THR_HIGH: csr_prdata = CSR_DATA_W'(thr_high_ff);
         REG_HOLD:     csr_prdata = CSR_DATA_W'(hold_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.thr_low  = thr_low_ff;
   assign cfg.thr_high = thr_high_ff;
   assign cfg.hold     = hold_ff;

   // The front end classifies each item as a failed read, a zero sample that
   // leaves the window alone, or a sample to push, and queues it.
   lsalc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (pop),
      .q_out      (q_out)
   );

   // The back end updates the window and running sum, divides, applies the
   // lamp hysteresis and holds the result until it is taken.
   lsalc_back #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_in       (q_out),
      .pop        (pop),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> bench/tb_light_sensor_average_lamp_control_core.sv
// ----------------------------------------------------------------------------
// Light sensor average lamp control core - testbench
// Drives light samples into the core, keeps its own model of the sliding
// window and the lamp hysteresis, and checks every result item field by field.
// ----------------------------------------------------------------------------
// The run starts with a short directed sequence on the empty window that fills
// and wraps it and exercises failed reads and zero samples. Then it steps through
// several threshold settings (defaults, both extremes, crossed thresholds,
// manual hold and a number of random settings). Random samples come in bursts
// around a level that is often picked near the active thresholds, so that the
// lamp walks through all of its transitions. Both channels idle at random,
// one phase runs with no idling at all, and once the receiver holds off long
// enough that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_light_sensor_average_lamp_control_core;

   timeunit 1ns;
   timeprecision 1ps;

   import lsalc_pkg::*;

   // Window depth of the core under test (default parameter).
   localparam int WINDOW_DEPTH = WINDOW_SIZE_DEF;
   // Index past the last register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   // Percentage of cycles in which a side idles.
   localparam int IDLE_PERCENT = 27;
   // Length of the one long receiver hold-off, and the result count at which
   // it starts.
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int HOLD_OFF_AFTER  = 60;
   // Settling time after the last due result, before the registers are touched
   // or the run ends.
   localparam int SETTLE_CYCLES = 40;
   // Cycles in a row with no item accepted on either channel before giving up.
   localparam int WATCHDOG_LIMIT = 2000;

   // Expected content of one result item.
   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      lamp_type            lamp_level;
   } lamp_result_type;

   // Tracks the window, the running sum and the lamp exactly as the core
   // should, and holds the results that are still due.
   class lamp_average_tracker;
      logic [SAMPLE_W-1:0] thr_low;
      logic [SAMPLE_W-1:0] thr_high;
      logic                hold;
      logic [SAMPLE_W-1:0] window_samples [WINDOW_DEPTH];
      logic [3:0]          oldest_idx;
      logic [3:0]          write_idx;
      logic [4:0]          fill;
      logic [15:0]         sum;
      lamp_type            lamp;
      lamp_result_type     results_due [$];
      int                  errors;
      int                  checked;
      int                  n_push;
      int                  n_zero;
      int                  n_fail;
      int                  n_held;
      int                  lamp_seen [3];

      function new();
         thr_low    = THR_LOW_RESET;
         thr_high   = THR_HIGH_RESET;
         hold       = 1'b0;
         oldest_idx = '0;
         write_idx  = '0;
         fill       = '0;
         sum        = '0;
         lamp       = LAMP_OFF;
         errors     = 0;
         checked    = 0;
         n_push     = 0;
         n_zero     = 0;
         n_fail     = 0;
         n_held     = 0;
         lamp_seen  = '{0, 0, 0};
      endfunction

      // Register write as the core should apply it; unknown indexes are dropped.
      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            REG_THR_LOW:  thr_low  = value[SAMPLE_W-1:0];
            REG_THR_HIGH: thr_high = value[SAMPLE_W-1:0];
            REG_HOLD:     hold     = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      // Called for every accepted input item.
      function void note_sample(logic [SAMPLE_W-1:0] sample, logic read_ok);
         logic [SAMPLE_W-1:0] avg;
         lamp_result_type     r;
         if (read_ok) begin
            if (sample != '0) begin
               // A full window drops its oldest sample before taking the new one.
               if (fill == 5'(WINDOW_DEPTH)) begin
                  sum        = sum - 16'(window_samples[oldest_idx]);
                  oldest_idx = oldest_idx + 4'd1;
               end
               window_samples[write_idx] = sample;
               sum       = sum + 16'(sample);
               write_idx = write_idx + 4'd1;
               if (fill < 5'(WINDOW_DEPTH))
                  fill = fill + 5'd1;
               n_push++;
            end else begin
               n_zero++;
            end
            avg = (fill == '0) ? '0 : 12'(sum / 16'(fill));
         end else begin
            avg = '0;
            n_fail++;
         end

         if (hold) begin
            n_held++;
         end else begin
            // A zero average forces the lamp to full before the lit rule runs.
            if (avg == '0)
               lamp = LAMP_FULL;
            if (lamp != LAMP_OFF) begin
               if (avg >= thr_high)
                  lamp = LAMP_OFF;
               else if (avg > thr_low)
                  lamp = LAMP_HALF;
            end else begin
               if (avg <= thr_low)
                  lamp = LAMP_FULL;
               else if (avg < thr_high)
                  lamp = LAMP_HALF;
            end
         end
         lamp_seen[lamp]++;
         r.average    = avg;
         r.lamp_level = lamp;
         results_due.push_back(r);
      endfunction

      // Called for every accepted result item.
      function void check_result(logic [RSP_DATA_W-1:0] data);
         lamp_result_type exp_r;
         if (results_due.size() == 0) begin
            $error("result item with no input item waiting: data 0x%04h", data);
            errors++;
            return;
         end
         exp_r = results_due.pop_front();
         checked++;
         if (data[11:0] !== exp_r.average) begin
            $error("average mismatch: expected %0d, actual %0d", exp_r.average, data[11:0]);
            errors++;
         end
         if (data[13:12] !== exp_r.lamp_level) begin
            $error("lamp_level mismatch: expected %0d, actual %0d",
                   exp_r.lamp_level, data[13:12]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [11:0] sample
   logic                  req_tuser;   // [0] read_ok
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [11:0] average, [13:12] lamp_level
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lamp_average_tracker tracker;
   // Set for one whole phase: neither side idles while it is high.
   bit                  no_idle = 1'b0;
   int                  quiet_cycles = 0;

   light_sensor_average_lamp_control_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Both channels are observed at the rising edge, before the core's own
   // updates of that edge land, so the handshake seen is the one that counts.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_sample(req_tdata[11:0], req_tuser);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tdata);
      end
   end

   // The run is stuck if no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no item accepted for %0d cycles.", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side. It idles at random, except in the no-idle phase, and once
   // holds off for a long stretch so that the core backs up into its input.
   initial begin
      int stall_left;
      bit stalled_once;
      stall_left   = 0;
      stalled_once = 1'b0;
      rsp_tready   = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!stalled_once && tracker.checked >= HOLD_OFF_AFTER) begin
            stalled_once = 1'b1;
            stall_left   = HOLD_OFF_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Offers one item and returns at the edge where it is accepted. The valid
   // stays high on return, so back-to-back items need no gap.
   task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic read_ok);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, sample};
      req_tuser  <= read_ok;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Register write: setup phase, then access phase with the write at its end.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.apply_reg(idx, value);
   endtask

   // Stops offering items and waits until every due result has come back,
   // then lets the core settle. The first edge makes sure the last accepted
   // item has been noted before the count of due results is looked at.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Starts a new register setting once the core is idle. Upper data bits are
   // random and must be ignored by the core.
   task automatic set_phase(input logic [SAMPLE_W-1:0] low, input logic [SAMPLE_W-1:0] high,
                            input logic hold);
      drain();
      write_reg(REG_THR_LOW,  {20'($urandom), low});
      write_reg(REG_THR_HIGH, {20'($urandom), high});
      write_reg(REG_HOLD,     {31'($urandom), hold});
   endtask

   function automatic logic [SAMPLE_W-1:0] level_near(input int centre, input int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0)
         v = 0;
      if (v > 4095)
         v = 4095;
      return SAMPLE_W'(v);
   endfunction

   // Random items in bursts around one light level. The level is picked near
   // a threshold in about two of five bursts, so that the average crosses it slowly.
   // Failed reads, zero samples and fully random samples are mixed in.
   task automatic run_random(input int count);
      int                  burst_left;
      int                  base;
      int                  pick;
      int                  r;
      logic [SAMPLE_W-1:0] sample;
      burst_left = 0;
      base       = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(4, 30);
            pick       = $urandom_range(0, 4);
            case (pick)
               0: base = tracker.thr_low;
               1: base = tracker.thr_high;
               2: base = $urandom_range(0, 60);
               3: base = $urandom_range(4030, 4095);
               default: base = $urandom_range(0, 4095);
            endcase
         end
         burst_left--;
         r = $urandom_range(0, 99);
         if (r < 8)
            send_item(12'($urandom), 1'b0);
         else if (r < 13)
            send_item('0, 1'b1);
         else if (r < 18)
            send_item(12'($urandom), 1'b1);
         else begin
            sample = level_near(base, 80);
            send_item(sample, 1'b1);
         end
      end
   endtask

   initial begin
      tracker     = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset thresholds. A good zero sample and a
      // failed read on the empty window both give average 0 and a full lamp.
      send_item('0, 1'b1);
      send_item(12'hFFF, 1'b0);
      // Bright single sample turns the lamp off; then the average drops into
      // the band between the thresholds and the lamp goes to half.
      send_item(12'hFFF, 1'b1);
      send_item(12'h001, 1'b1);
      // A zero sample on a nonempty window still reports the window average.
      send_item('0, 1'b1);
      send_item(12'hAAA, 1'b0);
      // Fill the window, then wrap it so the oldest samples drop out.
      for (int i = 0; i < 14; i++)
         send_item(i[0] ? 12'h555 : 12'hAAA, 1'b1);
      send_item(12'h800, 1'b1);
      send_item(12'h7FF, 1'b1);
      send_item(12'h555, 1'b0);
      send_item('0, 1'b1);
      send_item(12'hFFF, 1'b1);

      // Random part under the reset thresholds; the long receiver hold-off
      // falls in here.
      run_random(130);

      // Widest band: everything but 0 and 4095 is in between. No idling on
      // either side during this phase.
      set_phase(12'd0, 12'd4095, 1'b0);
      no_idle = 1'b1;
      run_random(110);
      no_idle = 1'b0;

      // Crossed thresholds at the extremes.
      set_phase(12'd4095, 12'd0, 1'b0);
      run_random(90);

      // Manual hold freezes the lamp while the window keeps averaging. A write
      // past the last register must not change anything.
      set_phase(12'd800, 12'd2500, 1'b1);
      write_reg(REG_UNUSED, $urandom);
      run_random(90);

      // Both thresholds at the top.
      set_phase(12'd4095, 12'd4095, 1'b0);
      run_random(70);

      // Random settings, mostly ordered, sometimes crossed.
      for (int p = 0; p < 4; p++) begin
         logic [SAMPLE_W-1:0] lo;
         logic [SAMPLE_W-1:0] hi;
         lo = 12'($urandom_range(0, 2047));
         hi = 12'($urandom_range(0, 4095));
         if (p != 3 && hi < lo)
            hi = lo + 12'($urandom_range(0, 4095 - lo));
         set_phase(lo, hi, 1'b0);
         run_random(100);
      end

      drain();
      $display("Covered %0d items: %0d window pushes, %0d good zero samples, %0d failed reads,",
               tracker.checked, tracker.n_push, tracker.n_zero, tracker.n_fail);
      $display("%0d items under manual hold; lamp off/half/full results: %0d/%0d/%0d.",
               tracker.n_held, tracker.lamp_seen[LAMP_OFF], tracker.lamp_seen[LAMP_HALF],
               tracker.lamp_seen[LAMP_FULL]);
      if (tracker.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> light_sensor_average_lamp_control_core.f
+incdir+rtl
rtl/lsalc_pkg.sv
rtl/lsalc_ram.sv
rtl/lsalc_front.sv
rtl/lsalc_back.sv
rtl/light_sensor_average_lamp_control_core.sv
bench/tb_light_sensor_average_lamp_control_core.sv
